// ===== rtl/touch_four_point_mapper_top_defines.svh =====
// ----------------------------------------------------------------------------
// touch_four_point_mapper_top_defines
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_FOUR_POINT_MAPPER_TOP_DEFINES_SVH
`define TOUCH_FOUR_POINT_MAPPER_TOP_DEFINES_SVH

// implication checked outside reset
`define TFPM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfpm assertion failed");

// implication checked on the next edge, outside reset
`define TFPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfpm assertion failed");

// implication checked at every edge, reset included
`define TFPM_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("tfpm assertion failed");

`endif

// ===== rtl/tfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfpm_pkg
// Types, widths and helpers for the four-point touch mapper.
// ----------------------------------------------------------------------------
package tfpm_pkg;

  localparam int COORD_BITS = 16;
  localparam int IO_W       = 16;
  localparam int CFG_W      = 32;
  localparam int HALF_LSB   = 16;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int MAG_W      = 2 * COORD_BITS + 1;
  localparam int VAL_W      = MAG_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TLS, REG_TLR, REG_TRS, REG_TRR, REG_BRS, REG_BRR, REG_BLS, REG_BLR
  } cfg_reg_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t                    ra;
    coord_t                    sa;
    coord_t                    lo;
    coord_t                    hi;
    logic signed [DIFF_W-1:0]  ds;
    coord_t                    dmag;
    logic                      dneg;
    logic                      zero;
  } axis_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               neg;
    coord_t             rem;
    logic [MAG_W-1:0]   work;
  } div_t;

  function automatic coord_t lo_half(logic [CFG_W-1:0] v);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic coord_t hi_half(logic [CFG_W-1:0] v);
    return v[HALF_LSB +: COORD_BITS];
  endfunction

  function automatic coord_t avg2(coord_t a, coord_t b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_BITS:1];
  endfunction

  function automatic axis_cfg_t make_axis(coord_t ra, coord_t rb, coord_t sa, coord_t sb);
    axis_cfg_t                c;
    logic signed [DIFF_W-1:0] den;
    den    = $signed({1'b0, rb}) - $signed({1'b0, ra});
    c.ra   = ra;
    c.sa   = sa;
    c.lo   = (sa < sb) ? sa : sb;
    c.hi   = (sa < sb) ? sb : sa;
    c.ds   = $signed({1'b0, sb}) - $signed({1'b0, sa});
    c.dneg = den[DIFF_W-1];
    c.dmag = den[DIFF_W-1] ? COORD_BITS'(-den) : COORD_BITS'(den);
    c.zero = (ra == rb);
    return c;
  endfunction

endpackage

// ===== rtl/tfpm_cfg.sv =====
// ----------------------------------------------------------------------------
// tfpm_cfg
// Calibration registers and per-axis edge values derived from them.
// ----------------------------------------------------------------------------
module tfpm_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tfpm_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [tfpm_pkg::CFG_W-1:0]           cfg_data,
  output tfpm_pkg::axis_cfg_t                  axis_x,
  output tfpm_pkg::axis_cfg_t                  axis_y
);

  logic [tfpm_pkg::CFG_W-1:0] regs [tfpm_pkg::NUM_REGS];
  tfpm_pkg::axis_cfg_t        axis_x_next;
  tfpm_pkg::axis_cfg_t        axis_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tfpm_pkg::NUM_REGS; i++) regs[i] <= '0;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    axis_x_next = tfpm_pkg::make_axis(
      tfpm_pkg::avg2(tfpm_pkg::hi_half(regs[tfpm_pkg::REG_TLR]),
                     tfpm_pkg::hi_half(regs[tfpm_pkg::REG_BLR])),
      tfpm_pkg::avg2(tfpm_pkg::hi_half(regs[tfpm_pkg::REG_TRR]),
                     tfpm_pkg::hi_half(regs[tfpm_pkg::REG_BRR])),
      tfpm_pkg::avg2(tfpm_pkg::lo_half(regs[tfpm_pkg::REG_TLS]),
                     tfpm_pkg::lo_half(regs[tfpm_pkg::REG_BLS])),
      tfpm_pkg::avg2(tfpm_pkg::lo_half(regs[tfpm_pkg::REG_TRS]),
                     tfpm_pkg::lo_half(regs[tfpm_pkg::REG_BRS])));
    axis_y_next = tfpm_pkg::make_axis(
      tfpm_pkg::avg2(tfpm_pkg::lo_half(regs[tfpm_pkg::REG_TLR]),
                     tfpm_pkg::lo_half(regs[tfpm_pkg::REG_TRR])),
      tfpm_pkg::avg2(tfpm_pkg::lo_half(regs[tfpm_pkg::REG_BLR]),
                     tfpm_pkg::lo_half(regs[tfpm_pkg::REG_BRR])),
      tfpm_pkg::avg2(tfpm_pkg::hi_half(regs[tfpm_pkg::REG_TLS]),
                     tfpm_pkg::hi_half(regs[tfpm_pkg::REG_TRS])),
      tfpm_pkg::avg2(tfpm_pkg::hi_half(regs[tfpm_pkg::REG_BLS]),
                     tfpm_pkg::hi_half(regs[tfpm_pkg::REG_BRS])));
  end

  always_ff @(posedge clk) begin
    axis_x <= axis_x_next;
    axis_y <= axis_y_next;
  end

endmodule

// ===== rtl/tfpm_div_stage.sv =====
// ----------------------------------------------------------------------------
// tfpm_div_stage
// One restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfpm_div_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tfpm_pkg::coord_t      dmag,
  input  tfpm_pkg::div_t        d_in,
  output tfpm_pkg::div_t        d_out
);

  logic [tfpm_pkg::COORD_BITS:0] trial;
  logic                          qbit;
  tfpm_pkg::div_t                d_next;

  always_comb begin
    trial = {d_in.rem, d_in.work[tfpm_pkg::MAG_W-1]};
    qbit  = (trial >= {1'b0, dmag});
    d_next       = d_in;
    d_next.rem   = qbit ? tfpm_pkg::COORD_BITS'(trial - {1'b0, dmag})
                        : trial[tfpm_pkg::COORD_BITS-1:0];
    d_next.work  = {d_in.work[tfpm_pkg::MAG_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.neg  <= d_next.neg;
      d_out.rem  <= d_next.rem;
      d_out.work <= d_next.work;
    end
  end

endmodule

// ===== rtl/tfpm_axis.sv =====
// ----------------------------------------------------------------------------
// tfpm_axis
// One axis: offset, multiply, magnitude, bit-serial pipelined divide, clamp.
// ----------------------------------------------------------------------------
module tfpm_axis (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  tfpm_pkg::coord_t      raw,
  input  tfpm_pkg::axis_cfg_t   cfg,
  output logic                  out_valid,
  output tfpm_pkg::coord_t      pos
);

  localparam int MAG_W = tfpm_pkg::MAG_W;
  localparam int VAL_W = tfpm_pkg::VAL_W;

  logic                                   v1, v2, v3;
  tfpm_pkg::coord_t                       raw1;
  logic signed [tfpm_pkg::DIFF_W-1:0]     diff2, diff_next;
  logic signed [tfpm_pkg::PROD_W-1:0]     prod3, prod_next;
  tfpm_pkg::div_t                         stg [MAG_W+1];
  logic signed [VAL_W-1:0]                qs, val;
  tfpm_pkg::coord_t                       pos_next;

  always_comb begin
    diff_next = $signed({1'b0, raw1}) - $signed({1'b0, cfg.ra});
    prod_next = tfpm_pkg::PROD_W'(diff2) * tfpm_pkg::PROD_W'(cfg.ds);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw1  <= raw;
      diff2 <= diff_next;
      prod3 <= prod_next;
    end
  end

  always_comb begin
    stg[0].valid = v3;
    stg[0].neg   = prod3[tfpm_pkg::PROD_W-1] ^ cfg.dneg;
    stg[0].rem   = '0;
    stg[0].work  = prod3[tfpm_pkg::PROD_W-1] ? MAG_W'(-prod3) : MAG_W'(prod3);
  end

  genvar i;
  for (i = 0; i < MAG_W; i++) begin : g_div
    tfpm_div_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .dmag  (cfg.dmag),
      .d_in  (stg[i]),
      .d_out (stg[i+1])
    );
  end

  // sign restore, offset by first edge, clamp to edge range (zero span: first edge)
  always_comb begin
    qs  = stg[MAG_W].neg ? -$signed(VAL_W'(stg[MAG_W].work))
                         :  $signed(VAL_W'(stg[MAG_W].work));
    val = $signed(VAL_W'(cfg.sa)) + qs;
    if (cfg.zero) begin
      pos_next = cfg.sa;
    end else if (val < $signed(VAL_W'(cfg.lo))) begin
      pos_next = cfg.lo;
    end else if (val > $signed(VAL_W'(cfg.hi))) begin
      pos_next = cfg.hi;
    end else begin
      pos_next = tfpm_pkg::COORD_BITS'(val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= stg[MAG_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= pos_next;
    end
  end

endmodule

// ===== rtl/touch_four_point_mapper_top.sv =====
// ----------------------------------------------------------------------------
// touch_four_point_mapper_top
// Four-point touch calibration: raw ADC sample in, clamped screen point out.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the pipeline is not held and returns one
// beat per sample, in order, through input, offset, multiply, 33 one-bit
// divide stages and the clamp/output register. The divider, one quotient
// bit per stage, sets the depth. The whole pipeline holds while a finished
// beat is stalled at the output, and in_stall follows that hold. Raw y maps
// to screen x, raw x to screen y. Writes act via the registered edge values.
module touch_four_point_mapper_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tfpm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [tfpm_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tfpm_pkg::IO_W-1:0]         adc_x,
  input  logic [tfpm_pkg::IO_W-1:0]         adc_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tfpm_pkg::IO_W-1:0]         pos_x,
  output logic [tfpm_pkg::IO_W-1:0]         pos_y
);

  tfpm_pkg::axis_cfg_t axis_x, axis_y;
  logic                en;
  logic                vx, vy;
  tfpm_pkg::coord_t    px, py;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vx && vy;
  assign pos_x     = tfpm_pkg::IO_W'(px);
  assign pos_y     = tfpm_pkg::IO_W'(py);

  tfpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .axis_x    (axis_x),
    .axis_y    (axis_y)
  );

  tfpm_axis u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .raw       (adc_y[tfpm_pkg::COORD_BITS-1:0]),
    .cfg       (axis_x),
    .out_valid (vx),
    .pos       (px)
  );

  tfpm_axis u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .raw       (adc_x[tfpm_pkg::COORD_BITS-1:0]),
    .cfg       (axis_y),
    .out_valid (vy),
    .pos       (py)
  );

endmodule

// ===== rtl/tfpm_checker.sv =====
// ----------------------------------------------------------------------------
// tfpm_checker
// Port-level checks on the mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_four_point_mapper_top_defines.svh"

module tfpm_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [tfpm_pkg::IO_W-1:0]         pos_x,
  input  logic [tfpm_pkg::IO_W-1:0]         pos_y
);

  // held output beat stays put
  `TFPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(pos_x) && $stable(pos_y))
  // input side stalls exactly when a finished beat is held
  `TFPM_ASSERT_IMPLY(a_in_stall, 1'b1, in_stall == (out_valid && out_stall))
  // reset empties the pipeline
  `TFPM_ASSERT_ALWAYS(a_rst_empty, rst ##1 1'b1, !out_valid)

endmodule

bind touch_four_point_mapper_top tfpm_checker u_tfpm_checker (.*);

// ===== test/tb_touch_four_point_mapper_top.sv =====
// ----------------------------------------------------------------------------
// tb_touch_four_point_mapper_top
// Self-checking bench for the four-point touch calibration mapper.
// ----------------------------------------------------------------------------
// Loads corner calibrations through the register port and streams raw ADC
// samples through the valid/stall channel. Each accepted beat is mapped by a
// local model of the edge averaging, interpolation and clamp, and the
// expected point is queued. Output beats are compared in order. Directed
// cases cover reset values, normal and reversed orientation, full-scale
// products and zero raw spans; random rounds vary calibration and traffic.
// ----------------------------------------------------------------------------
module tb_touch_four_point_mapper_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tfpm_pkg::*;

  typedef struct packed {
    logic [IO_W-1:0] pos_x;
    logic [IO_W-1:0] pos_y;
  } touch_point_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_TLS;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [IO_W-1:0]      adc_x     = '0;
  logic [IO_W-1:0]      adc_y     = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IO_W-1:0]      pos_x;
  logic [IO_W-1:0]      pos_y;

  logic [CFG_W-1:0] cal_regs [NUM_REGS];
  logic [CFG_W-1:0] next_cal [NUM_REGS];
  touch_point_t     expected_points [$];
  coord_t           x_win_a, x_win_b, y_win_a, y_win_b;
  int               fail_count    = 0;
  int               send_idle_pct = 0;
  int               stall_pct     = 0;
  int               hold_cycles   = 0;

  touch_four_point_mapper_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .adc_x     (adc_x),
    .adc_y     (adc_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---- mapping model ----

  function automatic coord_t low_coord(logic [CFG_W-1:0] w);
    return w[COORD_BITS-1:0];
  endfunction

  function automatic coord_t high_coord(logic [CFG_W-1:0] w);
    return w[HALF_LSB +: COORD_BITS];
  endfunction

  function automatic coord_t edge_mean(coord_t a, coord_t b);
    return coord_t'((int'(a) + int'(b)) >> 1);
  endfunction

  function automatic coord_t interpolate(coord_t raw, coord_t ra, coord_t rb,
                                         coord_t sa, coord_t sb);
    longint span, num, val, lo, hi;
    span = longint'(rb) - longint'(ra);
    if (span == 0) return sa;
    num = (longint'(raw) - longint'(ra)) * (longint'(sb) - longint'(sa));
    val = longint'(sa) + num / span;
    lo  = (sa < sb) ? longint'(sa) : longint'(sb);
    hi  = (sa < sb) ? longint'(sb) : longint'(sa);
    if (val < lo) val = lo;
    if (val > hi) val = hi;
    return coord_t'(val);
  endfunction

  // raw y drives screen x, raw x drives screen y
  function automatic touch_point_t predict_point(logic [IO_W-1:0] ax, logic [IO_W-1:0] ay);
    touch_point_t p;
    p.pos_x = IO_W'(interpolate(ay[COORD_BITS-1:0],
      edge_mean(high_coord(cal_regs[REG_TLR]), high_coord(cal_regs[REG_BLR])),
      edge_mean(high_coord(cal_regs[REG_TRR]), high_coord(cal_regs[REG_BRR])),
      edge_mean(low_coord(cal_regs[REG_TLS]), low_coord(cal_regs[REG_BLS])),
      edge_mean(low_coord(cal_regs[REG_TRS]), low_coord(cal_regs[REG_BRS]))));
    p.pos_y = IO_W'(interpolate(ax[COORD_BITS-1:0],
      edge_mean(low_coord(cal_regs[REG_TLR]), low_coord(cal_regs[REG_TRR])),
      edge_mean(low_coord(cal_regs[REG_BLR]), low_coord(cal_regs[REG_BRR])),
      edge_mean(high_coord(cal_regs[REG_TLS]), high_coord(cal_regs[REG_TRS])),
      edge_mean(high_coord(cal_regs[REG_BLS]), high_coord(cal_regs[REG_BRS]))));
    return p;
  endfunction

  // ---- calibration setup ----

  function automatic logic [CFG_W-1:0] corner_word(coord_t lo, coord_t hi);
    logic [CFG_W-1:0] w;
    w = '0;
    w[COORD_BITS-1:0]         = lo;
    w[HALF_LSB +: COORD_BITS] = hi;
    return w;
  endfunction

  function automatic coord_t nudge(coord_t v, int jit);
    return coord_t'(v + $urandom_range(jit));
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t rail();
    return $urandom_range(1) ? '1 : '0;
  endfunction

  task automatic build_corners(input coord_t sxa, sxb, sya, syb,
                               input coord_t rxa, rxb, rya, ryb, input int jit);
    next_cal[REG_TLS] = corner_word(nudge(sxa, jit), nudge(sya, jit));
    next_cal[REG_TLR] = corner_word(nudge(rxa, jit), nudge(rya, jit));
    next_cal[REG_TRS] = corner_word(nudge(sxb, jit), nudge(sya, jit));
    next_cal[REG_TRR] = corner_word(nudge(rxa, jit), nudge(ryb, jit));
    next_cal[REG_BRS] = corner_word(nudge(sxb, jit), nudge(syb, jit));
    next_cal[REG_BRR] = corner_word(nudge(rxb, jit), nudge(ryb, jit));
    next_cal[REG_BLS] = corner_word(nudge(sxa, jit), nudge(syb, jit));
    next_cal[REG_BLR] = corner_word(nudge(rxb, jit), nudge(rya, jit));
    x_win_a = rxa;
    x_win_b = rxb;
    y_win_a = rya;
    y_win_b = ryb;
  endtask

  task automatic load_calibration();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= next_cal[i];
      @(posedge clk);
      cal_regs[i] = next_cal[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_calibration();
    int     mode;
    coord_t rya;
    mode = $urandom_range(9);
    rya  = rand_coord();
    if (mode <= 5) begin
      build_corners(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rya,
                    ($urandom_range(5) == 0) ? rya : rand_coord(),
                    $urandom_range(1) ? $urandom_range(31) : 0);
    end else if (mode <= 7) begin
      for (int i = 0; i < NUM_REGS; i++) next_cal[i] = $urandom;
      x_win_a = '0;
      x_win_b = '1;
      y_win_a = '0;
      y_win_b = '1;
    end else if (mode == 8) begin
      build_corners(rail(), rail(), rail(), rail(), rail(), rail(), rail(), rail(), 0);
    end else begin
      // steep map: tiny raw span, random screen span
      build_corners(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rya, nudge(rya, 3), rya, nudge(rya, 2), 0);
      x_win_a = '0;
      x_win_b = '1;
    end
  endtask

  // ---- traffic ----

  task automatic send_sample(input logic [IO_W-1:0] ax, input logic [IO_W-1:0] ay);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_x    <= ax;
    adc_y    <= ay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.push_back(predict_point(ax, ay));
  endtask

  task automatic random_sample(output logic [IO_W-1:0] ax, output logic [IO_W-1:0] ay);
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) begin
      ax = IO_W'($urandom_range(x_win_a, x_win_b));
      ay = IO_W'($urandom_range(y_win_a, y_win_b));
    end else if (pick < 9) begin
      ax = IO_W'($urandom);
      ay = IO_W'($urandom);
    end else begin
      ax = rail();
      ay = rail();
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_output
    touch_point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected beat: pos_x %h pos_y %h", pos_x, pos_y);
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        if (pos_x !== want.pos_x) begin
          $error("pos_x expected %h actual %h", want.pos_x, pos_x);
          fail_count++;
        end
        if (pos_y !== want.pos_y) begin
          $error("pos_y expected %h actual %h", want.pos_y, pos_y);
          fail_count++;
        end
      end
    end
  end

  // ---- tests ----

  task automatic test_reset_state();
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample('1, '0);
    wait_drain();
  endtask

  task automatic test_linear_map();
    build_corners(16'd0, 16'd799, 16'd0, 16'd479, 16'd200, 16'd3900, 16'd300, 16'd3800, 0);
    // odd corner sums round down
    next_cal[REG_TLR] = next_cal[REG_TLR] + 1;
    next_cal[REG_BRS] = next_cal[REG_BRS] + 1;
    load_calibration();
    send_sample(16'd200, 16'd300);
    send_sample(16'd3900, 16'd3800);
    send_sample(16'd2050, 16'd2050);
    send_sample(16'd1234, 16'd777);
    send_sample(16'd0, 16'd100);
    send_sample(16'd4095, 16'd4000);
    wait_drain();
  endtask

  task automatic test_reversed_axes();
    build_corners(16'd700, 16'd20, 16'd460, 16'd15, 16'd3700, 16'd350, 16'd250, 16'd3600, 0);
    load_calibration();
    send_sample(16'd350, 16'd250);
    send_sample(16'd3700, 16'd3600);
    send_sample(16'd1999, 16'd1001);
    send_sample('1, '0);
    wait_drain();
  endtask

  task automatic test_full_scale();
    build_corners('0, '1, '1, '0, '0, '1, '0, '1, 0);
    load_calibration();
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample(16'h0001, 16'h8000);
    send_sample(16'h8000, 16'hFFFE);
    wait_drain();
    build_corners('1, '0, '0, '1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
    load_calibration();
    send_sample('0, '1);
    send_sample('1, '0);
    wait_drain();
  endtask

  task automatic test_zero_span();
    build_corners(16'd123, 16'd900, 16'd40, 16'd600, 16'd100, 16'd4000, 16'd2222, 16'd2222, 0);
    load_calibration();
    send_sample(16'd500, 16'd0);
    send_sample(16'd3000, 16'hFFFF);
    wait_drain();
    build_corners(16'd10, 16'd1000, 16'd555, 16'd5, 16'd777, 16'd777, 16'd50, 16'd4050, 0);
    load_calibration();
    send_sample(16'd0, 16'd2000);
    send_sample(16'hFFFF, 16'd60);
    wait_drain();
  endtask

  task automatic test_backpressure();
    logic [IO_W-1:0] ax, ay;
    send_idle_pct = 0;
    stall_pct     = 0;
    build_corners(16'd0, 16'd1023, 16'd0, 16'd767, 16'd150, 16'd3950, 16'd180, 16'd3900, 7);
    load_calibration();
    hold_cycles = 250;
    repeat (120) begin
      random_sample(ax, ay);
      send_sample(ax, ay);
    end
    wait_drain();
  endtask

  task automatic test_random_calibrations();
    logic [IO_W-1:0] ax, ay;
    for (int round = 0; round < 12; round++) begin
      case (round % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 64;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct     = 35;
        end
      endcase
      random_calibration();
      load_calibration();
      repeat (100) begin
        random_sample(ax, ay);
        send_sample(ax, ay);
      end
      wait_drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) cal_regs[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_linear_map();
    test_reversed_axes();
    test_full_scale();
    test_zero_span();
    test_backpressure();
    test_random_calibrations();
    if (fail_count == 0) begin
      $display("[touch_four_point_mapper_top] OK");
    end else begin
      $display("[touch_four_point_mapper_top] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[touch_four_point_mapper_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tfpm_pkg.sv
rtl/tfpm_cfg.sv
rtl/tfpm_div_stage.sv
rtl/tfpm_axis.sv
rtl/touch_four_point_mapper_top.sv
rtl/tfpm_checker.sv
test/tb_touch_four_point_mapper_top.sv
